### rtl/lane_marking_pixel_filter_defines.svh
// assertion macros for the lane marking pixel filter checker
// needs i_clk and i_rst_n in the scope where a macro is used

`ifndef LANE_MARKING_PIXEL_FILTER_DEFINES_SVH
`define LANE_MARKING_PIXEL_FILTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LMPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LMPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lmpf_pkg.sv
// shared types, constants and helper functions of the lane marking pixel filter
// no dependencies; used by every rtl module of the block

package lmpf_pkg;

    localparam int unsigned MAX_COLUMNS_DEF  = 1024;
    localparam int unsigned MAX_OFFSET_DEF   = 63;
    localparam int unsigned WINDOW_DEPTH_DEF = 128;

    localparam int unsigned PIXW      = 8;
    localparam int unsigned COLW      = 10;
    localparam int unsigned ROWW      = 10;
    localparam int unsigned CFGW      = 11;
    localparam int unsigned VANW      = 10;
    localparam int unsigned GROWW     = 6;
    localparam int unsigned OFFW      = 6;
    localparam int unsigned ERW       = 11;
    localparam int unsigned CFG_IDXW  = 2;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [CFGW-1:0]  CFG_COLS_RST = 11'd480;
    localparam logic [CFGW-1:0]  CFG_ROWS_RST = 11'd320;
    localparam logic [VANW-1:0]  CFG_VAN_RST  = 10'd160;
    localparam logic [GROWW-1:0] CFG_GROW_RST = 6'd21;

    localparam logic [OFFW-1:0] MIN_OFFSET = 6'd5;
    localparam logic [8:0]      DIFF_FLOOR = 9'd5;
    localparam logic [ERW-1:0]  ROW_LIMIT  = 11'd1024;

    typedef logic [CFG_IDXW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_COLS = 2'd0;
    localparam t_cfg_idx CFG_ROWS = 2'd1;
    localparam t_cfg_idx CFG_VAN  = 2'd2;
    localparam t_cfg_idx CFG_GROW = 2'd3;

    typedef struct packed {
        logic            cfg_wr;
        logic [ROWW-1:0] tgt_row;
    } t_div_req;

    typedef struct packed {
        logic [ERW-1:0]   eff_rows;
        logic [VANW-1:0]  van;
        logic [GROWW-1:0] grow;
    } t_div_cfg;

    typedef struct packed {
        logic            ok;
        logic [ROWW-1:0] row;
        logic [OFFW-1:0] offset;
    } t_div_sts;

    // delay k folded into a window of the given depth
    function automatic logic [6:0] tap_of(input logic [6:0] k, input int unsigned depth);
        logic [7:0] v;
        v = {1'b0, k};
        for (int i = 0; i < 4; i++) begin
            if (v >= 8'(depth)) begin
                v = v - 8'(depth);
            end
        end
        return v[6:0];
    endfunction

    // row following the given one, wrapping at the frame height
    function automatic logic [ROWW-1:0] succ_row(input logic [ROWW-1:0] row,
                                                 input logic [ERW-1:0] eff_rows);
        logic [ERW-1:0] s;
        s = ERW'(row) + ERW'(1);
        return (s >= eff_rows) ? '0 : s[ROWW-1:0];
    endfunction

endpackage

### rtl/lmpf_cell.sv
// one pixel cell of the window chain: holds one delayed pixel and drives it
// onto the tap buses when its position is selected; uses lmpf_pkg

module lmpf_cell import lmpf_pkg::*; #(
    parameter int unsigned TW = $clog2(WINDOW_DEPTH_DEF)
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [PIXW-1:0] i_pix,
    input  logic [TW-1:0]   i_idx,
    input  logic [TW-1:0]   i_sel_a,
    input  logic [TW-1:0]   i_sel_b,
    output logic [PIXW-1:0] o_pix,
    output logic [PIXW-1:0] o_tap_a,
    output logic [PIXW-1:0] o_tap_b
);

    logic [PIXW-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix   = r_pix;
    assign o_tap_a = (i_sel_a == i_idx) ? r_pix : '0;
    assign o_tap_b = (i_sel_b == i_idx) ? r_pix : '0;

endmodule

### rtl/lmpf_offset_div.sv
// row offset unit: 5 + growth*(row-vanishing)/(rows-vanishing), saturated,
// by shift and subtract, one quotient bit a cycle; uses lmpf_pkg

module lmpf_offset_div import lmpf_pkg::*; #(
    parameter int unsigned MAX_OFFSET = MAX_OFFSET_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    input  t_div_cfg i_cfg,
    output t_div_sts o_sts
);

    localparam int unsigned ITER = OFFW;
    localparam int unsigned CNTW = $clog2(ITER);
    localparam int unsigned NUMW = GROWW + ROWW;

    logic            r_busy;
    logic            r_ok;
    logic            r_stale;
    logic [ROWW-1:0] r_row;
    logic [CNTW-1:0] r_cnt;
    logic [NUMW-1:0] r_rem;
    logic [NUMW-1:0] r_dsh;
    logic [OFFW-1:0] r_q;

    logic            in_reg;
    logic [NUMW-1:0] num;
    logic [ERW-1:0]  divisor;
    logic            restart;
    logic            step_ge;
    logic [OFFW:0]   sum;

    always_comb begin
        in_reg  = (i_req.tgt_row >= i_cfg.van) && (ERW'(i_req.tgt_row) < i_cfg.eff_rows);
        num     = in_reg ? NUMW'(i_cfg.grow) * NUMW'(i_req.tgt_row - i_cfg.van) : '0;
        divisor = i_cfg.eff_rows - ERW'(i_cfg.van);
        restart = r_stale || (r_row != i_req.tgt_row) || (!r_ok && !r_busy);
        // a zero divisor only occurs outside the region, where the quotient is zero
        step_ge = (r_dsh != '0) && (r_rem >= r_dsh);
        sum     = (OFFW+1)'(MIN_OFFSET) + (OFFW+1)'(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ok    <= 1'b0;
            r_stale <= 1'b0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_dsh   <= '0;
            r_q     <= '0;
        end else if (i_req.cfg_wr) begin
            // new settings: drop the result and mark it stale so that the division restarts
            r_stale <= 1'b1;
            r_busy  <= 1'b0;
            r_ok    <= 1'b0;
        end else if (restart) begin
            r_stale <= 1'b0;
            r_busy  <= 1'b1;
            r_ok    <= 1'b0;
            r_row   <= i_req.tgt_row;
            r_cnt   <= '0;
            r_rem   <= num;
            r_dsh   <= NUMW'(divisor) << (ITER - 1);
            r_q     <= '0;
        end else if (r_busy) begin
            if (step_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[OFFW-2:0], step_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(ITER - 1)) begin
                r_busy <= 1'b0;
                r_ok   <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.ok     = r_ok && !r_busy && !r_stale;
        o_sts.row    = r_row;
        o_sts.offset = (sum > (OFFW+1)'(MAX_OFFSET)) ? OFFW'(MAX_OFFSET) : sum[OFFW-1:0];
    end

endmodule

### rtl/lane_marking_pixel_filter.sv
// Lane marking pixel filter. Grey pixels enter one per cycle while tready is high,
// in raster order on the slave stream; tuser marks the first pixel of a frame. Each
// decided pixel gives one result (mark, column, row) on the master stream, w pixels
// after the pixel itself, where w is the row offset; the last pixel of a row also
// gives the remaining w results of that row, which are flushed while no pixel is
// taken (at most 64 results per pixel). The window is a chain of WINDOW_DEPTH-1
// pixel cells that shifts with every pixel. The offset of the next row is computed
// during the current row by a shift-and-subtract unit; only a row of fewer than 8
// pixels, a frame start close to a row end, or a row end soon after a register
// write waits for it. Tlast is high on the last result caused by one input pixel.
// Uses lmpf_pkg, lmpf_cell and lmpf_offset_div.

module lane_marking_pixel_filter import lmpf_pkg::*; #(
    parameter int unsigned MAX_COLUMNS  = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_OFFSET   = MAX_OFFSET_DEF,
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [CFGW-1:0]      i_cfg_data,
    // pixel stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [7:0] pixel
    input  logic                 i_s_axis_tuser,   // frame_start
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [0] mark, [10:1] column, [20:11] row
    output logic                 o_m_axis_tlast    // last_of_run
);

    localparam int unsigned CW    = $clog2(MAX_COLUMNS);
    localparam int unsigned ECW   = CW + 1;
    localparam int unsigned XW    = (ECW > CFGW) ? ECW : CFGW;
    localparam int unsigned TW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned NCELL = WINDOW_DEPTH - 1;
    localparam logic [TW-1:0] TAP5A = TW'(tap_of(7'(MIN_OFFSET), WINDOW_DEPTH));
    localparam logic [TW-1:0] TAP5B = TW'(tap_of(7'({MIN_OFFSET, 1'b0}), WINDOW_DEPTH));

    // configuration registers
    logic [CFGW-1:0]  r_cfg_cols;
    logic [CFGW-1:0]  r_cfg_rows;
    logic [VANW-1:0]  r_cfg_van;
    logic [GROWW-1:0] r_cfg_grow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_COLS_RST;
            r_cfg_rows <= CFG_ROWS_RST;
            r_cfg_van  <= CFG_VAN_RST;
            r_cfg_grow <= CFG_GROW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: r_cfg_cols <= i_cfg_data;
                CFG_ROWS: r_cfg_rows <= i_cfg_data;
                CFG_VAN:  r_cfg_van  <= i_cfg_data[VANW-1:0];
                CFG_GROW: r_cfg_grow <= i_cfg_data[GROWW-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [XW-1:0]  cols_x;
    logic [ECW-1:0] eff_cols;
    logic [ERW-1:0] eff_rows;
    logic [ERW-1:0] rows_m1;

    always_comb begin
        cols_x = XW'(r_cfg_cols);
        if (cols_x == '0) begin
            eff_cols = ECW'(1);
        end else if (cols_x > XW'(MAX_COLUMNS)) begin
            eff_cols = ECW'(MAX_COLUMNS);
        end else begin
            eff_cols = cols_x[ECW-1:0];
        end
        if (r_cfg_rows == '0) begin
            eff_rows = ERW'(1);
        end else if (r_cfg_rows > ROW_LIMIT) begin
            eff_rows = ROW_LIMIT;
        end else begin
            eff_rows = r_cfg_rows;
        end
        rows_m1 = eff_rows - ERW'(1);
    end

    // control state
    logic [CW-1:0]   r_col,   n_col;
    logic [ROWW-1:0] r_row,   n_row;
    logic [OFFW-1:0] r_off,   n_off;
    logic [TW-1:0]   r_tap_a, n_tap_a;
    logic [TW-1:0]   r_tap_b, n_tap_b;
    logic            r_wait,  n_wait;
    logic            r_fl_act, n_fl_act;
    logic            r_o_valid, n_o_valid;

    // payload
    logic [CW-1:0]   r_fl_col, n_fl_col;
    logic [CW-1:0]   r_fl_end, n_fl_end;
    logic [ROWW-1:0] r_fl_row, n_fl_row;
    logic            r_o_mark, n_o_mark;
    logic [COLW-1:0] r_o_col,  n_o_col;
    logic [ROWW-1:0] r_o_row,  n_o_row;
    logic            r_o_last, n_o_last;

    logic out_free;
    logic s_ready;
    logic s_fire;
    logic m_fire;

    assign out_free = !r_o_valid || i_m_axis_tready;
    assign s_ready  = !r_wait && !r_fl_act && out_free;
    assign s_fire   = i_s_axis_tvalid && s_ready;
    assign m_fire   = r_o_valid && i_m_axis_tready;

    // offset unit
    t_div_req div_req;
    t_div_cfg div_cfg;
    t_div_sts div_sts;

    always_comb begin
        div_req.cfg_wr  = i_cfg_we;
        div_req.tgt_row = r_wait ? r_row : succ_row(r_row, eff_rows);
        div_cfg.eff_rows = eff_rows;
        div_cfg.van      = r_cfg_van;
        div_cfg.grow     = r_cfg_grow;
    end

    lmpf_offset_div #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_cfg   (div_cfg),
        .o_sts   (div_sts)
    );

    // current transaction
    logic            fs;
    logic [PIXW-1:0] cur_pix;
    logic [ROWW-1:0] row_a;
    logic [OFFW-1:0] w;
    logic [TW-1:0]   sel_a;
    logic [TW-1:0]   sel_b;
    logic [ECW-1:0]  c_x;
    logic [ECW-1:0]  w_x;
    logic [CW-1:0]   j;
    logic            has_dec;
    logic            eor;
    logic [ROWW-1:0] new_row;
    logic [ROWW-1:0] row_out;
    logic            in_region;

    always_comb begin
        fs      = i_s_axis_tuser;
        cur_pix = i_s_axis_tdata[PIXW-1:0];
        row_a   = fs ? '0 : r_row;
        w       = fs ? MIN_OFFSET : r_off;
        sel_a   = fs ? TAP5A : r_tap_a;
        sel_b   = fs ? TAP5B : r_tap_b;
        c_x     = fs ? '0 : ECW'(r_col);
        w_x     = ECW'(w);
        j       = CW'(c_x - w_x);
        has_dec = c_x >= w_x;
        eor     = (c_x + ECW'(1)) >= eff_cols;
        new_row = succ_row(row_a, eff_rows);
        // rows counted past a shrunk frame report the last row on wrap
        if (eor) begin
            row_out = (new_row == '0) ? rows_m1[ROWW-1:0] : row_a;
        end else begin
            row_out = row_a;
        end
        in_region = (row_a >= r_cfg_van) && (ERW'(row_a) < eff_rows);
    end

    // pixel window chain
    logic [PIXW-1:0] w_chain [0:NCELL];
    logic [PIXW-1:0] w_tap_a [1:NCELL];
    logic [PIXW-1:0] w_tap_b [1:NCELL];

    assign w_chain[0] = cur_pix;

    for (genvar k = 1; k <= NCELL; k++) begin : g_cell
        lmpf_cell #(
            .TW (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_en    (s_fire),
            .i_pix   (w_chain[k-1]),
            .i_idx   (TW'(k)),
            .i_sel_a (sel_a),
            .i_sel_b (sel_b),
            .o_pix   (w_chain[k]),
            .o_tap_a (w_tap_a[k]),
            .o_tap_b (w_tap_b[k])
        );
    end

    logic [PIXW-1:0] pix_a;
    logic [PIXW-1:0] pix_b;

    always_comb begin
        // a delay folded to zero reads the pixel being written
        pix_a = (sel_a == '0) ? cur_pix : '0;
        pix_b = (sel_b == '0) ? cur_pix : '0;
        for (int k = 1; k <= NCELL; k++) begin
            pix_a = pix_a | w_tap_a[k];
            pix_b = pix_b | w_tap_b[k];
        end
    end

    // peak test on the pixel w back against its two neighbours at distance w
    logic            pos_l;
    logic            pos_r;
    logic [PIXW-1:0] dl;
    logic [PIXW-1:0] dr;
    logic [PIXW-1:0] dmin;
    logic [8:0]      d;
    logic            mark;

    always_comb begin
        pos_l = pix_a > pix_b;
        pos_r = pix_a > cur_pix;
        dl    = pix_a - pix_b;
        dr    = pix_a - cur_pix;
        dmin  = (dl < dr) ? dl : dr;
        d     = {dmin, 1'b0};
        mark  = in_region && (c_x >= (w_x << 1)) && (c_x < eff_cols) && pos_l && pos_r &&
                (d > DIFF_FLOOR) && (d >= 9'(pix_a >> 1));
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_off     = r_off;
        n_tap_a   = r_tap_a;
        n_tap_b   = r_tap_b;
        n_wait    = r_wait;
        n_fl_act  = r_fl_act;
        n_o_valid = r_o_valid;
        n_fl_col  = r_fl_col;
        n_fl_end  = r_fl_end;
        n_fl_row  = r_fl_row;
        n_o_mark  = r_o_mark;
        n_o_col   = r_o_col;
        n_o_row   = r_o_row;
        n_o_last  = r_o_last;

        if (m_fire) begin
            n_o_valid = 1'b0;
        end

        if (r_wait && div_sts.ok && (div_sts.row == r_row)) begin
            n_off   = div_sts.offset;
            n_tap_a = TW'(tap_of(7'(div_sts.offset), WINDOW_DEPTH));
            n_tap_b = TW'(tap_of({div_sts.offset, 1'b0}, WINDOW_DEPTH));
            n_wait  = 1'b0;
        end

        // row tail
        if (r_fl_act && out_free) begin
            n_o_valid = 1'b1;
            n_o_mark  = 1'b0;
            n_o_col   = COLW'(r_fl_col);
            n_o_row   = r_fl_row;
            n_o_last  = (r_fl_col == r_fl_end);
            if (r_fl_col == r_fl_end) begin
                n_fl_act = 1'b0;
            end else begin
                n_fl_col = r_fl_col + CW'(1);
            end
        end

        if (s_fire) begin
            if (eor) begin
                n_col = '0;
                n_row = new_row;
                if (div_sts.ok && (div_sts.row == new_row)) begin
                    n_off   = div_sts.offset;
                    n_tap_a = TW'(tap_of(7'(div_sts.offset), WINDOW_DEPTH));
                    n_tap_b = TW'(tap_of({div_sts.offset, 1'b0}, WINDOW_DEPTH));
                end else begin
                    n_wait = 1'b1;
                end
            end else begin
                n_col = CW'(c_x + ECW'(1));
                if (fs) begin
                    n_row   = '0;
                    n_off   = MIN_OFFSET;
                    n_tap_a = TAP5A;
                    n_tap_b = TAP5B;
                end
            end

            if (has_dec) begin
                n_o_valid = 1'b1;
                n_o_mark  = mark;
                n_o_col   = COLW'(j);
                n_o_row   = row_out;
                n_o_last  = !eor;
            end else if (eor) begin
                // row no longer than the offset: tail starts at column zero
                n_o_valid = 1'b1;
                n_o_mark  = 1'b0;
                n_o_col   = '0;
                n_o_row   = row_out;
                n_o_last  = (c_x == '0);
            end

            if (eor && (has_dec || (c_x != '0))) begin
                n_fl_act = 1'b1;
                n_fl_col = has_dec ? (j + CW'(1)) : CW'(1);
                n_fl_end = CW'(c_x);
                n_fl_row = row_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_off     <= MIN_OFFSET;
            r_tap_a   <= TAP5A;
            r_tap_b   <= TAP5B;
            r_wait    <= 1'b0;
            r_fl_act  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_off     <= n_off;
            r_tap_a   <= n_tap_a;
            r_tap_b   <= n_tap_b;
            r_wait    <= n_wait;
            r_fl_act  <= n_fl_act;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fl_col <= n_fl_col;
        r_fl_end <= n_fl_end;
        r_fl_row <= n_fl_row;
        r_o_mark <= n_o_mark;
        r_o_col  <= n_o_col;
        r_o_row  <= n_o_row;
        r_o_last <= n_o_last;
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_o_row, r_o_col, r_o_mark});
    assign o_m_axis_tlast  = r_o_last;

endmodule

### rtl/lmpf_checker.sv
// port-level checker for the lane marking pixel filter, bound to the top level
// uses lmpf_pkg and the assertion macros of lane_marking_pixel_filter_defines.svh

`include "lane_marking_pixel_filter_defines.svh"

module lmpf_checker import lmpf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast
);

    // a stalled result holds
    `LMPF_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "result changed while stalled")

    // no pixel taken while the result register is blocked
    `LMPF_ASSERT_SAME(a_in_blocked, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready, "pixel taken while output stalled")

    // no pixel taken while a row tail is still being sent
    `LMPF_ASSERT_SAME(a_tail_blocks, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready, "pixel taken during row tail")

    // a marked pixel lies at least the minimum offset from the left border
    `LMPF_ASSERT_SAME(a_mark_border, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[10:1] >= 10'(MIN_OFFSET), "mark in border column")

endmodule

bind lane_marking_pixel_filter lmpf_checker u_lmpf_checker (.*);
